[hdl/ipsd_pkg.sv]
// Package with the types, codes and constants shared by the patch stream decoder.
`default_nettype none

package ipsd_pkg;

  // Codes of the kind field of a result word.
  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_FILL      = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_BAD_MAGIC = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_e;

  // Parse phases of the front end.
  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_ADDR  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_COUNT = 3'd4,
    PH_FILL  = 3'd5,
    PH_HALT  = 3'd6
  } phase_e;

  // Register indexes of the configuration channel.
  localparam logic RegAddressOffset = 1'b0;
  localparam logic RegImageSize     = 1'b1;

  // Header text "PATCH" and the address that marks the end-of-file record.
  localparam logic [39:0] MagicWord  = 40'h5041544348;
  localparam logic [23:0] EofAddress = 24'h454F46;

  // Index of the final header byte, and of the final byte of each record field.
  localparam logic [2:0] MagicLastIdx = 3'd4;
  localparam logic [2:0] AddrLastIdx  = 3'd2;
  localparam logic [2:0] HalfLastIdx  = 3'd1;

  // Command passed from the parser to the address unit. The base is the
  // unsigned patch address of the first byte and last_addr that of the final
  // byte (two's complement, as an empty run ends one below its start).
  typedef struct packed {
    kind_e        kind;
    logic [24:0]  base;
    logic [26:0]  last_addr;
    logic [15:0]  count;
    logic [7:0]   value;
  } cmd_t;

  // Result word as it leaves the block.
  typedef struct packed {
    kind_e        kind;
    logic [31:0]  target_address;
    logic [15:0]  run_count;
    logic [7:0]   write_value;
    logic         extends_image;
  } res_t;

  // Expected header byte at a given position.
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] sel;
    case (pos)
      3'd0:    sel = MagicWord[39:32];
      3'd1:    sel = MagicWord[31:24];
      3'd2:    sel = MagicWord[23:16];
      3'd3:    sel = MagicWord[15:8];
      default: sel = MagicWord[7:0];
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

[hdl/ipsd_if.sv]
// Handshake interfaces for the patch byte, result and configuration channels.
`default_nettype none

interface ipsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       last_byte;

  modport source (output valid, output patch_byte, output last_byte, input ready);
  modport sink   (input valid, input patch_byte, input last_byte, output ready);
endinterface

interface ipsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] target_address;
  logic [15:0] run_count;
  logic [7:0]  write_value;
  logic        extends_image;

  modport source (output valid, output kind, output target_address, output run_count,
                  output write_value, output extends_image, input ready);
  modport sink   (input valid, input kind, input target_address, input run_count,
                  input write_value, input extends_image, output ready);
endinterface

interface ipsd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/ipsd_front.sv]
// Front end: parses the patch byte stream into write, fill and status commands.
`default_nettype none

module ipsd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    patch_byte_i,
  input  wire logic          last_byte_i,
  output      logic          push_o,
  output      ipsd_pkg::cmd_t cmd_o
);

  import ipsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  fcount_q, fcount_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic        ok_q, ok_d;

  logic [23:0] addr_shift;
  logic [15:0] len_shift;
  logic [15:0] idx_inc;
  logic [24:0] data_base;
  logic [26:0] fill_last;
  logic        ok_next;
  logic        finished;

  // Field assembly and address sums used by several phases.
  assign addr_shift = {addr_q[15:0], patch_byte_i};
  assign len_shift  = {len_q[7:0], patch_byte_i};
  assign idx_inc    = idx_q + 16'd1;
  assign data_base  = {1'b0, addr_q} + {9'b0, idx_q};
  assign fill_last  = {3'b000, addr_q} + {11'b0, len_q} - 27'd1;
  assign ok_next    = ok_q & (patch_byte_i == magic_byte(fcount_q));

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      fcount_q <= '0;
      addr_q   <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      ok_q     <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      fcount_q <= fcount_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      ok_q     <= ok_d;
    end
  end

  // Next phase and the command that an accepted byte produces.
  always_comb begin
    phase_d          = phase_q;
    fcount_d         = fcount_q;
    addr_d           = addr_q;
    len_d            = len_q;
    idx_d            = idx_q;
    ok_d             = ok_q;
    finished         = 1'b0;
    push_o           = 1'b0;
    cmd_o.kind       = KIND_WRITE;
    cmd_o.base       = '0;
    cmd_o.last_addr  = '0;
    cmd_o.count      = '0;
    cmd_o.value      = '0;

    if (accept_i) begin
      case (phase_q)
        PH_MAGIC: begin
          ok_d     = ok_next;
          fcount_d = fcount_q + 3'd1;
          if (fcount_q == MagicLastIdx) begin
            fcount_d = '0;
            if (!ok_next) begin
              push_o     = 1'b1;
              cmd_o.kind = KIND_BAD_MAGIC;
              finished   = 1'b1;
              phase_d    = PH_HALT;
            end else begin
              phase_d = PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          addr_d   = addr_shift;
          fcount_d = fcount_q + 3'd1;
          if (fcount_q == AddrLastIdx) begin
            fcount_d = '0;
            if (addr_shift == EofAddress) begin
              push_o     = 1'b1;
              cmd_o.kind = KIND_DONE;
              finished   = 1'b1;
              phase_d    = PH_HALT;
            end else begin
              len_d   = '0;
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          len_d    = len_shift;
          fcount_d = fcount_q + 3'd1;
          if (fcount_q == HalfLastIdx) begin
            fcount_d = '0;
            idx_d    = '0;
            phase_d  = (len_shift != '0) ? PH_DATA : PH_COUNT;
          end
        end
        PH_DATA: begin
          // One byte write per data byte; the offset is applied downstream.
          push_o          = 1'b1;
          cmd_o.kind      = KIND_WRITE;
          cmd_o.base      = data_base;
          cmd_o.last_addr = {2'b00, data_base};
          cmd_o.count     = 16'd1;
          cmd_o.value     = patch_byte_i;
          idx_d           = idx_inc;
          if (idx_inc == len_q) begin
            addr_d  = '0;
            phase_d = PH_ADDR;
          end
        end
        PH_COUNT: begin
          len_d    = len_shift;
          fcount_d = fcount_q + 3'd1;
          if (fcount_q == HalfLastIdx) begin
            fcount_d = '0;
            phase_d  = PH_FILL;
          end
        end
        PH_FILL: begin
          push_o          = 1'b1;
          cmd_o.kind      = KIND_FILL;
          cmd_o.base      = {1'b0, addr_q};
          cmd_o.last_addr = fill_last;
          cmd_o.count     = len_q;
          cmd_o.value     = patch_byte_i;
          addr_d          = '0;
          phase_d         = PH_ADDR;
        end
        default: begin
          phase_d  = PH_HALT;
          finished = 1'b1;
        end
      endcase

      // The final byte of a stream either closes it cleanly or reports a
      // truncation in place of anything else, then rearms the parser.
      if (last_byte_i) begin
        if (!finished) begin
          push_o          = 1'b1;
          cmd_o.kind      = KIND_TRUNC;
          cmd_o.base      = '0;
          cmd_o.last_addr = '0;
          cmd_o.count     = '0;
          cmd_o.value     = '0;
        end
        phase_d  = PH_MAGIC;
        fcount_d = '0;
        addr_d   = '0;
        len_d    = '0;
        idx_d    = '0;
        ok_d     = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ipsd_cmd_queue.sv]
// Short first-in first-out queue of commands between the parser and the address unit.
`default_nettype none

module ipsd_cmd_queue #(
  parameter int Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ipsd_pkg::cmd_t push_data_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      ipsd_pkg::cmd_t pop_data_o,
  output      logic           valid_o
);

  import ipsd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = store_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/ipsd_back.sv]
// Back end: applies the address offset, clips and drops, and holds the result word.
`default_nettype none

module ipsd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    address_offset_i,
  input  wire logic [31:0]    image_size_i,
  input  wire logic           cmd_valid_i,
  input  wire ipsd_pkg::cmd_t cmd_i,
  output      logic           cmd_pop_o,
  output      logic           res_valid_o,
  input  wire logic           res_ready_i,
  output      ipsd_pkg::res_t res_o
);

  import ipsd_pkg::*;

  logic [33:0] off_ext;
  logic        s1_valid_q;
  kind_e       s1_kind_q;
  logic [33:0] s1_start_q, s1_end_q;
  logic [15:0] s1_count_q;
  logic [7:0]  s1_value_q;
  logic        s1_load, s1_move;

  logic        out_valid_q;
  res_t        out_q, res_d;
  logic        keep;
  logic        out_free;
  logic        start_neg, end_neg;
  logic        start_ext, end_ext;
  logic [15:0] clipped_count;

  // Pipeline control: the output register frees up when it is empty or taken.
  assign out_free  = !out_valid_q || res_ready_i;
  assign s1_move   = s1_valid_q && out_free;
  assign s1_load   = !s1_valid_q || out_free;
  assign cmd_pop_o = cmd_valid_i && s1_load;
  assign off_ext   = {{2{address_offset_i[31]}}, address_offset_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= cmd_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_move && keep;
      end
    end
  end

  // Offset stage: signed start and end addresses of the write or run.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_kind_q  <= cmd_i.kind;
      s1_start_q <= {9'b0, cmd_i.base} + off_ext;
      s1_end_q   <= {{7{cmd_i.last_addr[26]}}, cmd_i.last_addr} + off_ext;
      s1_count_q <= cmd_i.count;
      s1_value_q <= cmd_i.value;
    end
  end

  // Clip and compare. A non-negative address always fits in 33 bits here.
  assign start_neg     = s1_start_q[33];
  assign end_neg       = s1_end_q[33];
  assign start_ext     = s1_start_q[32:0] >= {1'b0, image_size_i};
  assign end_ext       = s1_end_q[32:0] >= {1'b0, image_size_i};
  assign clipped_count = s1_end_q[15:0] + 16'd1;

  always_comb begin
    res_d.kind           = s1_kind_q;
    res_d.target_address = '0;
    res_d.run_count      = '0;
    res_d.write_value    = '0;
    res_d.extends_image  = 1'b0;
    keep                 = 1'b1;
    case (s1_kind_q)
      KIND_WRITE: begin
        keep                 = !start_neg;
        res_d.target_address = s1_start_q[31:0];
        res_d.run_count      = 16'd1;
        res_d.write_value    = s1_value_q;
        res_d.extends_image  = start_ext;
      end
      KIND_FILL: begin
        // A run that starts below zero begins at zero and keeps its end.
        keep                 = (s1_count_q != '0) && !end_neg;
        res_d.target_address = start_neg ? '0 : s1_start_q[31:0];
        res_d.run_count      = start_neg ? clipped_count : s1_count_q;
        res_d.write_value    = s1_value_q;
        res_d.extends_image  = end_ext;
      end
      default: begin
        keep = 1'b1;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

[hdl/ips_patch_stream_decoder_unit.sv]
// Top level of the patch stream decoder: configuration registers and the three parts.
`default_nettype none

// Decodes a patch stream in the common IPS format, one byte per word on the
// patch channel, into byte writes, fill runs and status words (done, bad
// header, truncated stream). A byte is taken in every clock cycle while the
// command queue between the parser and the address unit has space, so the
// sustained rate is one byte per cycle whenever the result side keeps up;
// the parser handles each byte in the cycle it is accepted, and its result
// reaches the result channel through the queue, which is written on the
// accepting edge, then the offset stage and the output register. Bytes
// that produce no result, such as header, address and length bytes, are
// taken all the same. The two configuration registers, address offset
// and image size, are written through the configuration channel, which is
// always ready, and should be changed only while no stream is in flight.
// There is no start-up sequence after reset.
module ips_patch_stream_decoder_unit #(
  parameter int QueueDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipsd_in_if.sink    patch_i,
  ipsd_out_if.source result_o,
  ipsd_cfg_if.sink   cfg_i
);

  import ipsd_pkg::*;

  logic [31:0] offset_q, size_q;
  logic        accept;
  logic        push, full, pop, cmd_valid;
  cmd_t        push_cmd, pop_cmd;
  res_t        res;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      size_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegAddressOffset: offset_q <= cfg_i.data;
        RegImageSize:     size_q   <= cfg_i.data;
        default:          offset_q <= offset_q;
      endcase
    end
  end

  // Byte acceptance follows the space left in the command queue.
  assign patch_i.ready = !full;
  assign accept        = patch_i.valid && !full;

  ipsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .patch_byte_i (patch_i.patch_byte),
    .last_byte_i  (patch_i.last_byte),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ipsd_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .valid_o     (cmd_valid)
  );

  ipsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .address_offset_i (offset_q),
    .image_size_i     (size_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (pop_cmd),
    .cmd_pop_o        (pop),
    .res_valid_o      (result_o.valid),
    .res_ready_i      (result_o.ready),
    .res_o            (res)
  );

  // Result word fields.
  assign result_o.kind           = res.kind;
  assign result_o.target_address = res.target_address;
  assign result_o.run_count      = res.run_count;
  assign result_o.write_value    = res.write_value;
  assign result_o.extends_image  = res.extends_image;

endmodule

`default_nettype wire

[test/ips_patch_stream_decoder_unit_test.sv]
// Self-checking testbench for the patch stream decoder: directed and random patch streams.
`timescale 1ns / 1ps

module ips_patch_stream_decoder_unit_test;
  import ipsd_pkg::*;

  localparam int NumPhases     = 7;
  localparam int PhaseBytes    = 170;
  localparam int HoldOffCycles = 400;
  localparam int SettleCycles  = 10;
  localparam int WatchdogLimit = 3000;
  localparam int DirRowCount   = 29;

  logic clk_i;
  logic rst_ni;

  ipsd_in_if  patch_if ();
  ipsd_out_if result_if ();
  ipsd_cfg_if cfg_if ();

  ips_patch_stream_decoder_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .patch_i  (patch_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Own copy of the configuration and of the parser state.
  logic signed [31:0] addr_offset;
  logic [31:0]        img_size;
  phase_e             parse_ph;
  logic [2:0]         fcount;
  logic [23:0]        rec_addr;
  logic [15:0]        rec_len;
  logic [15:0]        data_idx;
  logic               magic_good;

  res_t        due_words[$];
  int unsigned mismatches;
  bit          steady;
  bit          stall_req;
  int unsigned quiet_cycles;

  // One directed byte: the expected word is typed in only where it is plain.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    res_t       word;
  } row_t;

  row_t dir_rows [DirRowCount] = '{
    // Header.
    '{8'h50, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0}, '{8'h54, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0}, '{8'h48, 1'b0, 1'b0, '0},
    // One data byte at address zero; with an empty image it extends it.
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{KIND_WRITE, 32'h0, 16'd1, 8'hFF, 1'b1}},
    // Fill run of the largest count at the highest address.
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b1, '{KIND_FILL, 32'h00FF_FFFF, 16'hFFFF, 8'hAA, 1'b1}},
    // End-of-file record, then a trailing byte that is ignored.
    '{8'h45, 1'b0, 1'b0, '0}, '{8'h4F, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b1, '{KIND_DONE, 32'h0, 16'h0, 8'h0, 1'b0}},
    '{8'h00, 1'b1, 1'b0, '0},
    // Wrong final header byte, ending the stream on the same byte.
    '{8'h50, 1'b0, 1'b0, '0}, '{8'h41, 1'b0, 1'b0, '0}, '{8'h54, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{KIND_BAD_MAGIC, 32'h0, 16'h0, 8'h0, 1'b0}},
    // A stream cut short inside the header.
    '{8'h50, 1'b1, 1'b1, '{KIND_TRUNC, 32'h0, 16'h0, 8'h0, 1'b0}}
  };

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Returns the parser to its state after reset.
  function automatic void rearm_parser();
    parse_ph   = PH_MAGIC;
    fcount     = '0;
    rec_addr   = '0;
    rec_len    = '0;
    data_idx   = '0;
    magic_good = 1'b1;
  endfunction

  // Appends one word to the end of a stream under construction.
  function automatic void append_byte(ref bit [8:0] q[$], input bit [8:0] w);
    q.insert(q.size(), w);
  endfunction

  // Works out the word, if any, that one patch byte gives, and advances the parser.
  function automatic void decode_patch_byte(input logic [7:0] b, input logic lst,
                                            output bit yields, output res_t word);
    longint     a;
    longint     start;
    longint     cnt;
    longint     size_v;
    longint     offs_v;
    logic [7:0] want;
    bit         closed;
    yields = 1'b0;
    word   = '0;
    closed = 1'b0;
    size_v = longint'(img_size);
    offs_v = longint'(addr_offset);
    case (parse_ph)
      PH_MAGIC: begin
        want = MagicWord[8*(4-fcount) +: 8];
        if (b != want) magic_good = 1'b0;
        if (fcount == MagicLastIdx) begin
          fcount = '0;
          if (!magic_good) begin
            yields   = 1'b1;
            word     = '{KIND_BAD_MAGIC, 32'h0, 16'h0, 8'h0, 1'b0};
            closed   = 1'b1;
            parse_ph = PH_HALT;
          end else begin
            parse_ph = PH_ADDR;
          end
        end else begin
          fcount = fcount + 3'd1;
        end
      end
      PH_ADDR: begin
        rec_addr = {rec_addr[15:0], b};
        if (fcount == AddrLastIdx) begin
          fcount = '0;
          if (rec_addr == EofAddress) begin
            yields   = 1'b1;
            word     = '{KIND_DONE, 32'h0, 16'h0, 8'h0, 1'b0};
            closed   = 1'b1;
            parse_ph = PH_HALT;
          end else begin
            parse_ph = PH_LEN;
            rec_len  = '0;
          end
        end else begin
          fcount = fcount + 3'd1;
        end
      end
      PH_LEN: begin
        rec_len = {rec_len[7:0], b};
        if (fcount == HalfLastIdx) begin
          fcount   = '0;
          data_idx = '0;
          parse_ph = (rec_len != 0) ? PH_DATA : PH_COUNT;
        end else begin
          fcount = fcount + 3'd1;
        end
      end
      PH_DATA: begin
        a = longint'(rec_addr) + longint'(data_idx) + offs_v;
        data_idx = data_idx + 16'd1;
        if (data_idx == rec_len) begin
          parse_ph = PH_ADDR;
          rec_addr = '0;
        end
        // Writes that land below zero are dropped.
        if (a >= 0) begin
          yields = 1'b1;
          word   = '{KIND_WRITE, a[31:0], 16'd1, b, a >= size_v};
        end
      end
      PH_COUNT: begin
        rec_len = {rec_len[7:0], b};
        if (fcount == HalfLastIdx) begin
          fcount   = '0;
          parse_ph = PH_FILL;
        end else begin
          fcount = fcount + 3'd1;
        end
      end
      PH_FILL: begin
        start = longint'(rec_addr) + offs_v;
        cnt   = longint'(rec_len);
        // A run starting below zero is clipped to its part at or above zero.
        if (start < 0) begin
          cnt   = cnt + start;
          start = 0;
        end
        if (cnt > 0) begin
          yields = 1'b1;
          word   = '{KIND_FILL, start[31:0], cnt[15:0], b, (start + cnt - 1) >= size_v};
        end
        parse_ph = PH_ADDR;
        rec_addr = '0;
      end
      default: begin
        parse_ph = PH_HALT;
        closed   = 1'b1;
      end
    endcase
    // The final byte of a stream that is still open reports truncation instead.
    if (lst) begin
      if (!closed) begin
        yields = 1'b1;
        word   = '{KIND_TRUNC, 32'h0, 16'h0, 8'h0, 1'b0};
      end
      rearm_parser();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  // Offers one patch word, with random gaps, and records what it should give.
  task automatic send_word(input logic [7:0] b, input logic lst, input bit typed,
                           input res_t typed_word);
    bit   yields;
    res_t word;
    if (!steady && $urandom_range(0, 99) < 16) begin
      patch_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 16);
    end
    patch_if.valid      <= 1'b1;
    patch_if.patch_byte <= b;
    patch_if.last_byte  <= lst;
    do @(posedge clk_i); while (!patch_if.ready);
    decode_patch_byte(b, lst, yields, word);
    if (typed) begin
      yields = 1'b1;
      word   = typed_word;
    end
    if (yields) due_words.insert(due_words.size(), word);
  endtask

  // Lets the block run dry so that the registers may be changed.
  task automatic drain_block();
    patch_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both registers back to back, valid held high between them.
  task automatic set_config(input logic [31:0] offset_v, input logic [31:0] size_v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= RegAddressOffset;
    cfg_if.data  <= offset_v;
    do @(posedge clk_i); while (!cfg_if.ready);
    addr_offset  = offset_v;
    cfg_if.index <= RegImageSize;
    cfg_if.data  <= size_v;
    do @(posedge clk_i); while (!cfg_if.ready);
    img_size     = size_v;
    cfg_if.valid <= 1'b0;
  endtask

  // Builds one patch stream: mostly well formed, some with a bad header, some cut
  // short, and a few of plain noise. The final word carries the last flag.
  task automatic build_stream(ref bit [8:0] q[$]);
    int unsigned style;
    int unsigned len;
    int unsigned cut;
    logic [23:0] addr;
    logic [15:0] cnt;
    q.delete();
    style = $urandom_range(0, 99);
    if (style < 6) begin
      repeat ($urandom_range(1, 12)) append_byte(q, {1'b0, 8'($urandom)});
    end else begin
      for (int i = 0; i < 5; i++) append_byte(q, {1'b0, MagicWord[8*(4-i) +: 8]});
      if (style < 12) q[$urandom_range(0, 4)][7:0] ^= 8'($urandom_range(1, 255));
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 3))
          0:       addr = 24'($urandom_range(0, 64));
          1:       addr = 24'hFF_FFFF - 24'($urandom_range(0, 64));
          default: addr = 24'($urandom);
        endcase
        append_byte(q, {1'b0, addr[23:16]});
        append_byte(q, {1'b0, addr[15:8]});
        append_byte(q, {1'b0, addr[7:0]});
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0:       cnt = 16'h0;
            1:       cnt = 16'hFFFF;
            2:       cnt = 16'($urandom);
            default: cnt = 16'($urandom_range(1, 80));
          endcase
          append_byte(q, 9'h0);
          append_byte(q, 9'h0);
          append_byte(q, {1'b0, cnt[15:8]});
          append_byte(q, {1'b0, cnt[7:0]});
          append_byte(q, {1'b0, 8'($urandom)});
        end else begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          append_byte(q, {1'b0, 8'(len >> 8)});
          append_byte(q, {1'b0, 8'(len)});
          repeat (len) append_byte(q, {1'b0, 8'($urandom)});
        end
      end
      append_byte(q, {1'b0, EofAddress[23:16]});
      append_byte(q, {1'b0, EofAddress[15:8]});
      append_byte(q, {1'b0, EofAddress[7:0]});
      repeat ($urandom_range(0, 2)) append_byte(q, {1'b0, 8'($urandom)});
    end
    // Cut some streams short at a random word.
    if (style >= 12 && style < 28) begin
      cut = $urandom_range(0, q.size() - 1);
      while (q.size() > cut + 1) void'(q.pop_back());
    end
    q[q.size() - 1][8] = 1'b1;
  endtask

  // Result side: random stalls, and one long hold-off when asked for.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        result_if.ready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Compares every accepted result word with the oldest one due.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d addr %0h", result_if.kind,
                                  result_if.target_address));
      end else begin
        want = due_words.pop_front();
        if (result_if.kind != want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", result_if.kind, want.kind));
        if (result_if.target_address != want.target_address)
          report_mismatch($sformatf("target_address %0h, expected %0h",
                                    result_if.target_address, want.target_address));
        if (result_if.run_count != want.run_count)
          report_mismatch($sformatf("run_count %0h, expected %0h", result_if.run_count,
                                    want.run_count));
        if (result_if.write_value != want.write_value)
          report_mismatch($sformatf("write_value %0h, expected %0h", result_if.write_value,
                                    want.write_value));
        if (result_if.extends_image != want.extends_image)
          report_mismatch($sformatf("extends_image %0b, expected %0b",
                                    result_if.extends_image, want.extends_image));
      end
    end
  end

  // Watchdog: ends the run after too long without any word moving.
  always @(posedge clk_i) begin
    if ((patch_if.valid && patch_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no word moved for %0d cycles", WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: directed table at reset settings, then random streams per setting.
  initial begin
    bit [8:0]    stream_words[$];
    int unsigned sent;
    mismatches   = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    stall_req    = 1'b0;
    addr_offset  = '0;
    img_size     = '0;
    rearm_parser();
    rst_ni              <= 1'b0;
    patch_if.valid      <= 1'b0;
    patch_if.patch_byte <= '0;
    patch_if.last_byte  <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= RegAddressOffset;
    cfg_if.data         <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].word);
    drain_block();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_config(32'h0000_0000, 32'h0000_0040);
        1: set_config(32'hFFFF_FFE0, 32'h0000_0020);
        2: set_config(32'h8000_0000, 32'hFFFF_FFFF);
        3: set_config(32'h7FFF_FFFF, 32'h8000_0000);
        4: set_config(32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000,
                      32'($urandom_range(0, 32'h0100_0000)));
        5: set_config(32'hFF80_0000, 32'h0080_0000);
        default: set_config(32'($urandom), 32'($urandom));
      endcase
      // The first setting starts with a long hold-off on the result side.
      stall_req = (p == 0);
      steady    = (p == 4);
      sent      = 0;
      while (sent < PhaseBytes) begin
        build_stream(stream_words);
        foreach (stream_words[i])
          send_word(stream_words[i][7:0], stream_words[i][8], 1'b0, '0);
        sent += stream_words.size();
      end
      drain_block();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ipsd_pkg.sv
hdl/ipsd_if.sv
hdl/ipsd_front.sv
hdl/ipsd_cmd_queue.sv
hdl/ipsd_back.sv
hdl/ips_patch_stream_decoder_unit.sv
test/ips_patch_stream_decoder_unit_test.sv
